### sv/nce_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and lookup tables of the noise voice.
// No dependencies; every other file of the block imports this package.
package nce_pkg;

   // Accumulators hold a 32-bit value plus one step, so one extra bit.
   localparam int ACC_W   = 33;
   localparam int CSR_W   = 30;
   localparam int CSR_IDX_W = 3;

   // Item kinds.
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Voice register selects.
   localparam logic [2:0] REG_CONTROL = 3'd0;
   localparam logic [2:0] REG_PERIOD  = 3'd1;
   localparam logic [2:0] REG_LENGTH  = 3'd2;
   localparam logic [2:0] REG_ENABLE  = 3'd3;
   localparam logic [2:0] REG_FRAME   = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_STEP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_FOUR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_FIVE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE       = 3'd4;

   // Reset values.
   localparam logic [23:0]    STEP_RESET       = 24'd3663000;
   localparam logic [CSR_W-1:0] FRAME_FOUR_RESET = 30'd488727552;
   localparam logic [CSR_W-1:0] FRAME_FIVE_RESET = 30'd610909440;
   localparam logic [7:0]     LEN_RESET        = 8'h0A;
   localparam logic [11:0]    PERIOD_RESET     = 12'h004;
   localparam logic [3:0]     ENV_MAX          = 4'hF;
   localparam logic [14:0]    LFSR_RESET       = 15'd1;

   typedef struct packed {
      logic       kind;
      logic [2:0] reg_select;
      logic [7:0] write_value;
   } req_type;

   typedef struct packed {
      logic [3:0] sample;
      logic       length_running;
   } rsp_type;

   function automatic logic [7:0] len_lookup(input logic [4:0] idx);
      logic [7:0] v;
      unique case (idx)
         5'd0:  v = 8'h0A;  5'd1:  v = 8'hFE;  5'd2:  v = 8'h14;  5'd3:  v = 8'h02;
         5'd4:  v = 8'h28;  5'd5:  v = 8'h04;  5'd6:  v = 8'h50;  5'd7:  v = 8'h06;
         5'd8:  v = 8'hA0;  5'd9:  v = 8'h08;  5'd10: v = 8'h3C;  5'd11: v = 8'h0A;
         5'd12: v = 8'h0E;  5'd13: v = 8'h0C;  5'd14: v = 8'h1A;  5'd15: v = 8'h0E;
         5'd16: v = 8'h0C;  5'd17: v = 8'h10;  5'd18: v = 8'h18;  5'd19: v = 8'h12;
         5'd20: v = 8'h30;  5'd21: v = 8'h14;  5'd22: v = 8'h60;  5'd23: v = 8'h16;
         5'd24: v = 8'hC0;  5'd25: v = 8'h18;  5'd26: v = 8'h48;  5'd27: v = 8'h1A;
         5'd28: v = 8'h10;  5'd29: v = 8'h1C;  5'd30: v = 8'h20;  default: v = 8'h1E;
      endcase
      return v;
   endfunction

   function automatic logic [11:0] period_lookup(input logic pal, input logic [3:0] idx);
      logic [11:0] v;
      if (pal) begin
         unique case (idx)
            4'd0:  v = 12'h004;  4'd1:  v = 12'h008;  4'd2:  v = 12'h00E;  4'd3:  v = 12'h01E;
            4'd4:  v = 12'h03C;  4'd5:  v = 12'h058;  4'd6:  v = 12'h076;  4'd7:  v = 12'h094;
            4'd8:  v = 12'h0BC;  4'd9:  v = 12'h0EC;  4'd10: v = 12'h162;  4'd11: v = 12'h1D8;
            4'd12: v = 12'h2C4;  4'd13: v = 12'h3B0;  4'd14: v = 12'h762;  default: v = 12'hEC2;
         endcase
      end else begin
         unique case (idx)
            4'd0:  v = 12'h004;  4'd1:  v = 12'h008;  4'd2:  v = 12'h010;  4'd3:  v = 12'h020;
            4'd4:  v = 12'h040;  4'd5:  v = 12'h060;  4'd6:  v = 12'h080;  4'd7:  v = 12'h0A0;
            4'd8:  v = 12'h0CA;  4'd9:  v = 12'h0FE;  4'd10: v = 12'h17C;  4'd11: v = 12'h1FC;
            4'd12: v = 12'h2FA;  4'd13: v = 12'h3F8;  4'd14: v = 12'h7F2;  default: v = 12'hFE4;
         endcase
      end
      return v;
   endfunction

endpackage

### sv/noise_channel_lfsr_envelope_unit.sv
`timescale 1ns / 1ps
// Noise voice top level. A register write beat is taken while idle and gives no result.
// A sample tick gives its result after F frame steps and P noise shifts, each one pass
// of the shared add/subtract unit; the noise shifts are skipped with a silent length
// counter, the frame steps with a zero frame period. The next beat is taken once idle.
// An earlier result still stalled holds the tick in its last state until it leaves.
// Synchronous active-high reset restores all voice state and configuration.
module noise_channel_lfsr_envelope_unit
   import nce_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int PER_W = 12 + FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FRAME_LOAD, ST_FRAME_LOOP, ST_PER_LOAD, ST_PER_LOOP, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration.
   logic [23:0]      step_ff, step_in;
   logic [CSR_W-1:0] frame_four_ff, frame_four_in;
   logic [CSR_W-1:0] frame_five_ff, frame_five_in;
   logic             pal_ff, pal_in;
   logic             mute_ff, mute_in;

   // Voice state.
   logic [7:0]  length_count_ff, length_count_in;
   logic        length_halt_ff, length_halt_in;
   logic        channel_on_ff, channel_on_in;
   logic        env_start_ff, env_start_in;
   logic        env_constant_ff, env_constant_in;
   logic        env_loop_ff, env_loop_in;
   logic [3:0]  env_level_ff, env_level_in;
   logic [3:0]  env_rate_ff, env_rate_in;
   logic [3:0]  env_divider_ff, env_divider_in;
   logic [3:0]  fixed_volume_ff, fixed_volume_in;
   logic [31:0] frame_accum_ff, frame_accum_in;
   logic [1:0]  frame_phase_ff, frame_phase_in;
   logic        five_step_ff, five_step_in;
   logic [11:0] period_cycles_ff, period_cycles_in;
   logic [31:0] period_accum_ff, period_accum_in;
   logic [14:0] lfsr_ff, lfsr_in;
   logic        short_mode_ff, short_mode_in;

   // Working accumulator and result register.
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [ACC_W-1:0] alu_a, alu_b, alu_res;
   logic             alu_sub, alu_borrow;
   logic [CSR_W-1:0] frame_period;
   logic [PER_W-1:0] noise_period;
   logic             req_take, rsp_free, fb;
   logic [3:0]       volume;

   nce_addsub u_addsub (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .do_sub (alu_sub),
      .result (alu_res),
      .borrow (alu_borrow)
   );

   assign frame_period = five_step_ff ? frame_five_ff : frame_four_ff;
   assign noise_period = {period_cycles_ff, {FRAC_BITS{1'b0}}};
   assign req_take     = req_valid & ~req_stall;
   assign rsp_free     = ~rsp_valid_ff | ~rsp_stall;
   assign fb           = lfsr_ff[0] ^ (short_mode_ff ? lfsr_ff[6] : lfsr_ff[1]);
   assign volume       = env_constant_ff ? fixed_volume_ff : env_level_ff;

   // Operand selection for the shared unit.
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = ACC_W'(step_ff);
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_FRAME_LOAD: alu_a = ACC_W'(frame_accum_ff);
         ST_PER_LOAD:   alu_a = ACC_W'(period_accum_ff);
         ST_FRAME_LOOP: begin
            alu_b   = ACC_W'(frame_period);
            alu_sub = 1'b1;
         end
         ST_PER_LOOP: begin
            alu_b   = ACC_W'(noise_period);
            alu_sub = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      frame_four_in   = frame_four_ff;
      frame_five_in   = frame_five_ff;
      pal_in          = pal_ff;
      mute_in         = mute_ff;
      length_count_in = length_count_ff;
      length_halt_in  = length_halt_ff;
      channel_on_in   = channel_on_ff;
      env_start_in    = env_start_ff;
      env_constant_in = env_constant_ff;
      env_loop_in     = env_loop_ff;
      env_level_in    = env_level_ff;
      env_rate_in     = env_rate_ff;
      env_divider_in  = env_divider_ff;
      fixed_volume_in = fixed_volume_ff;
      frame_accum_in  = frame_accum_ff;
      frame_phase_in  = frame_phase_ff;
      five_step_in    = five_step_ff;
      period_cycles_in = period_cycles_ff;
      period_accum_in = period_accum_ff;
      lfsr_in         = lfsr_ff;
      short_mode_in   = short_mode_ff;
      acc_in          = acc_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;

      if (csr_we) begin
         unique case (csr_index)
            CSR_STEP:       step_in       = csr_wdata[23:0];
            CSR_FRAME_FOUR: frame_four_in = csr_wdata;
            CSR_FRAME_FIVE: frame_five_in = csr_wdata;
            CSR_PAL:        pal_in        = csr_wdata[0];
            CSR_MUTE:       mute_in       = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_payload.kind == KIND_WRITE) begin
                  unique case (req_payload.reg_select)
                     REG_CONTROL: begin
                        if (req_payload.write_value[4]) begin
                           fixed_volume_in = req_payload.write_value[3:0];
                        end else begin
                           env_rate_in = req_payload.write_value[3:0];
                        end
                        env_constant_in = req_payload.write_value[4];
                        length_halt_in  = req_payload.write_value[5];
                        env_loop_in     = req_payload.write_value[5];
                     end
                     REG_PERIOD: begin
                        period_cycles_in = period_lookup(pal_ff,
                                                         req_payload.write_value[3:0]);
                        short_mode_in    = req_payload.write_value[7];
                     end
                     REG_LENGTH: begin
                        if (channel_on_ff) begin
                           length_count_in = len_lookup(req_payload.write_value[7:3]);
                        end
                        env_level_in   = ENV_MAX;
                        env_divider_in = 4'd0;
                        env_start_in   = 1'b1;
                     end
                     REG_ENABLE: begin
                        channel_on_in = req_payload.write_value[3];
                        if (!req_payload.write_value[3]) begin
                           length_count_in = 8'd0;
                        end
                     end
                     REG_FRAME: five_step_in = req_payload.write_value[7];
                     default: ;
                  endcase
               end else begin
                  state_in = ST_FRAME_LOAD;
               end
            end
         end
         ST_FRAME_LOAD: begin
            // A zero frame period leaves the frame sequencer and its accumulator alone.
            if (frame_period == '0) begin
               state_in = (length_count_ff != 8'd0) ? ST_PER_LOAD : ST_DONE;
            end else begin
               acc_in   = alu_res;
               state_in = ST_FRAME_LOOP;
            end
         end
         ST_FRAME_LOOP: begin
            if (!alu_borrow) begin
               acc_in = alu_res;
               if (frame_phase_ff == 2'd0 && length_count_ff != 8'd0 && !length_halt_ff) begin
                  length_count_in = length_count_ff - 8'd1;
               end
               if (env_start_ff) begin
                  env_start_in   = 1'b0;
                  env_level_in   = ENV_MAX;
                  env_divider_in = env_rate_ff;
               end else if (env_divider_ff != 4'd0) begin
                  env_divider_in = env_divider_ff - 4'd1;
               end else begin
                  env_divider_in = env_rate_ff;
                  if (env_level_ff != 4'd0) begin
                     env_level_in = env_level_ff - 4'd1;
                  end else if (env_loop_ff) begin
                     env_level_in = ENV_MAX;
                  end
               end
               frame_phase_in = frame_phase_ff + 2'd1;
            end else begin
               frame_accum_in = acc_ff[31:0];
               state_in = (length_count_ff != 8'd0) ? ST_PER_LOAD : ST_DONE;
            end
         end
         ST_PER_LOAD: begin
            acc_in   = alu_res;
            state_in = ST_PER_LOOP;
         end
         ST_PER_LOOP: begin
            if (!alu_borrow) begin
               acc_in  = alu_res;
               lfsr_in = {fb, lfsr_ff[14:1]};
            end else begin
               period_accum_in = acc_ff[31:0];
               state_in        = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.sample = (length_count_ff != 8'd0 && !mute_ff && !lfsr_ff[0]) ?
                               volume : 4'd0;
               rsp_in.length_running = channel_on_ff & (length_count_ff != 8'd0);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= STEP_RESET;
         frame_four_ff    <= FRAME_FOUR_RESET;
         frame_five_ff    <= FRAME_FIVE_RESET;
         pal_ff           <= 1'b0;
         mute_ff          <= 1'b0;
         length_count_ff  <= LEN_RESET;
         length_halt_ff   <= 1'b0;
         channel_on_ff    <= 1'b1;
         env_start_ff     <= 1'b1;
         env_constant_ff  <= 1'b0;
         env_loop_ff      <= 1'b0;
         env_level_ff     <= ENV_MAX;
         env_rate_ff      <= 4'd0;
         env_divider_ff   <= 4'd0;
         fixed_volume_ff  <= 4'd0;
         frame_accum_ff   <= 32'd0;
         frame_phase_ff   <= 2'd0;
         five_step_ff     <= 1'b0;
         period_cycles_ff <= PERIOD_RESET;
         period_accum_ff  <= 32'd0;
         lfsr_ff          <= LFSR_RESET;
         short_mode_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         frame_four_ff    <= frame_four_in;
         frame_five_ff    <= frame_five_in;
         pal_ff           <= pal_in;
         mute_ff          <= mute_in;
         length_count_ff  <= length_count_in;
         length_halt_ff   <= length_halt_in;
         channel_on_ff    <= channel_on_in;
         env_start_ff     <= env_start_in;
         env_constant_ff  <= env_constant_in;
         env_loop_ff      <= env_loop_in;
         env_level_ff     <= env_level_in;
         env_rate_ff      <= env_rate_in;
         env_divider_ff   <= env_divider_in;
         fixed_volume_ff  <= fixed_volume_in;
         frame_accum_ff   <= frame_accum_in;
         frame_phase_ff   <= frame_phase_in;
         five_step_ff     <= five_step_in;
         period_cycles_ff <= period_cycles_in;
         period_accum_ff  <= period_accum_in;
         lfsr_ff          <= lfsr_in;
         short_mode_ff    <= short_mode_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/nce_addsub.sv
`timescale 1ns / 1ps
// Shared adder/subtractor used by the sequencer for every accumulator step.
// Depends on nce_pkg for the accumulator width.
module nce_addsub
   import nce_pkg::*;
(
   input  logic [ACC_W-1:0] op_a,
   input  logic [ACC_W-1:0] op_b,
   input  logic             do_sub,
   output logic [ACC_W-1:0] result,
   output logic             borrow
);

   logic [ACC_W:0] full;

   always_comb begin
      if (do_sub) begin
         full = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         full = {1'b0, op_a} + {1'b0, op_b};
      end
   end

   // The extra top bit is only a borrow when subtracting.
   assign result = full[ACC_W-1:0];
   assign borrow = do_sub & full[ACC_W];

endmodule

### sv/nce_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the noise voice, bound to the top level.
// Depends on nce_pkg for the beat types and item kinds.
module nce_checker
   import nce_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // A taken tick starts the sequencer and so raises the request stall.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.kind == KIND_TICK |=> req_stall)
      else $error("tick beat did not start the sequencer");

   // A silent length counter always gives a zero sample.
   a_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.length_running |-> rsp_payload.sample == 4'd0)
      else $error("sample nonzero with length counter stopped");

endmodule

bind noise_channel_lfsr_envelope_unit nce_checker u_nce_checker (.*);
